// ----- rtl/nrsh_pkg.sv -----
package nrsh_pkg;

   localparam int POS_W    = 32;
   localparam int DIR_W    = 16;
   localparam int RAD_W    = 31;
   localparam int SLOT_W   = 6;
   localparam int CNT_W    = 7;
   localparam int DIST_W   = 32;
   localparam int ENTRY_W  = 3 * POS_W + RAD_W;
   localparam int SQIN_W   = 2 * RAD_W;
   localparam int ROOT_W   = RAD_W;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- rtl/nrsh_if.sv -----
interface nrsh_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [nrsh_pkg::SLOT_W-1:0]         slot;
   logic signed [nrsh_pkg::POS_W-1:0]   pos_x;
   logic signed [nrsh_pkg::POS_W-1:0]   pos_y;
   logic signed [nrsh_pkg::POS_W-1:0]   pos_z;
   logic [nrsh_pkg::RAD_W-1:0]          radius;
   logic signed [nrsh_pkg::DIR_W-1:0]   dir_x;
   logic signed [nrsh_pkg::DIR_W-1:0]   dir_y;
   logic signed [nrsh_pkg::DIR_W-1:0]   dir_z;

   modport source (output valid, kind, slot, pos_x, pos_y, pos_z, radius, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, kind, slot, pos_x, pos_y, pos_z, radius, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface nrsh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [nrsh_pkg::SLOT_W-1:0]         hit_index;
   logic signed [nrsh_pkg::DIST_W-1:0]  hit_distance;

   modport source (output valid, hit, hit_index, hit_distance, input ready);
   modport sink (input valid, hit, hit_index, hit_distance, output ready);
endinterface

interface nrsh_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nrsh_pkg::CNT_W-1:0]          active_spheres;

   modport source (output valid, active_spheres, input ready);
   modport sink (input valid, active_spheres, output ready);
endinterface

// ----- rtl/nrsh_ram.sv -----
module nrsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/nrsh_sqrt.sv -----
module nrsh_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nrsh_pkg::SQIN_W-1:0]   radicand,
   output logic                          done,
   output logic [nrsh_pkg::ROOT_W-1:0]   root
);

   localparam int REM_W = nrsh_pkg::ROOT_W + 2;
   localparam int CNT_W = $clog2(nrsh_pkg::ROOT_W);

   logic [nrsh_pkg::SQIN_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [nrsh_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            rem_sh;
   logic [REM_W-1:0]            trial;

   // One result bit per cycle: bring down two radicand bits and try root*4+1.
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[nrsh_pkg::SQIN_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(nrsh_pkg::ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[nrsh_pkg::SQIN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[nrsh_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[nrsh_pkg::ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/nearest_ray_sphere_hit_core.sv -----
// Nearest ray-sphere hit search. A load request writes one sphere (center and
// radius) into a table slot and returns nothing. A query request walks the
// first active_spheres slots (at most MAX_SPHERES) one sphere at a time, using
// one shared 36x18 multiplier for |L|^2, r^2, the dot product and tca^2, then
// one shared square-root unit that produces a bit per cycle. A sphere may be
// rejected early, before it reaches the square root. The block takes no new
// request while a query runs, but a finished response may wait in its output
// register while loads and the next query proceed. Unwritten table slots must
// not be searched.
module nearest_ray_sphere_hit_core #(
   parameter int MAX_SPHERES = 64
) (
   input  logic         clock,
   input  logic         reset,
   nrsh_req_if.sink     req_ch,
   nrsh_rsp_if.source   rsp_ch,
   nrsh_csr_if.sink     csr_ch
);

   localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CW = $clog2(MAX_SPHERES + 1);
   localparam int PW = nrsh_pkg::POS_W;
   localparam int LW = PW + 1;
   localparam int RW = nrsh_pkg::RAD_W;

   localparam logic [3:0] STEP_LX_LO  = 4'd0;
   localparam logic [3:0] STEP_LX_HI  = 4'd1;
   localparam logic [3:0] STEP_LY_LO  = 4'd2;
   localparam logic [3:0] STEP_LY_HI  = 4'd3;
   localparam logic [3:0] STEP_LZ_LO  = 4'd4;
   localparam logic [3:0] STEP_LZ_HI  = 4'd5;
   localparam logic [3:0] STEP_R_LO   = 4'd6;
   localparam logic [3:0] STEP_R_HI   = 4'd7;
   localparam logic [3:0] STEP_DOT_X  = 4'd8;
   localparam logic [3:0] STEP_DOT_Y  = 4'd9;
   localparam logic [3:0] STEP_DOT_Z  = 4'd10;
   localparam logic [3:0] STEP_TCA_LO = 4'd11;
   localparam logic [3:0] STEP_TCA_HI = 4'd12;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_LOAD, ST_MUL, ST_ACC, ST_CHECK,
      ST_DIFF, ST_SQRT, ST_PICK, ST_NEXT, ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [nrsh_pkg::CNT_W-1:0] active_ff, active_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [CW-1:0]              i_ff, i_in;
   logic signed [PW-1:0]       ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic signed [nrsh_pkg::DIR_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [LW-1:0]       lx_ff, lx_in, ly_ff, ly_in, lz_ff, lz_in;
   logic [RW-1:0]              r_ff, r_in;
   logic [3:0]                 step_ff, step_in;
   logic [53:0]                prod_ff, prod_in;
   logic [71:0]                acc_ff, acc_in;
   logic [65:0]                l2_ff, l2_in;
   logic [61:0]                r2_ff, r2_in;
   logic signed [35:0]         tca_ff, tca_in;
   logic [65:0]                d2_ff, d2_in;
   logic                       sq_start_ff, sq_start_in;
   logic [61:0]                sq_rad_ff, sq_rad_in;
   logic signed [36:0]         t_ff, t_in;
   logic                       found_ff, found_in;
   logic signed [36:0]         best_ff, best_in;
   logic [nrsh_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [nrsh_pkg::SLOT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [nrsh_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [nrsh_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [15:0]                 slot_ext;
   logic                        slot_ok;
   logic [CW-1:0]               n_sel;
   logic [15:0]                 i_ext;

   logic [35:0] mlx, mly, mlz, mr, mtca;
   logic [35:0] mdx, mdy, mdz;
   logic [35:0] op_a;
   logic [17:0] op_b;
   logic        op_neg, op_shift, op_first, op_last;
   logic [71:0] term, sterm;

   logic                        sq_done;
   logic [nrsh_pkg::ROOT_W-1:0] sq_root;

   function automatic logic [35:0] mag36(input logic signed [35:0] v);
      mag36 = v[35] ? (~v + 36'd1) : v;
   endfunction

   nrsh_ram #(
      .WIDTH (nrsh_pkg::ENTRY_W),
      .DEPTH (MAX_SPHERES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (i_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   nrsh_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start_ff),
      .radicand (sq_rad_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign slot_ext  = {{(16 - nrsh_pkg::SLOT_W){1'b0}}, req_ch.slot};
   assign slot_ok   = 32'(slot_ext) < 32'(MAX_SPHERES);
   assign ram_waddr = slot_ext[AW-1:0];
   assign ram_wdata = {req_ch.pos_x, req_ch.pos_y, req_ch.pos_z, req_ch.radius};
   assign n_sel     = (32'(active_ff) > 32'(MAX_SPHERES)) ? CW'(MAX_SPHERES)
                                                          : CW'(active_ff);
   assign i_ext     = 16'(i_ff);

   assign mlx  = mag36(36'(lx_ff));
   assign mly  = mag36(36'(ly_ff));
   assign mlz  = mag36(36'(lz_ff));
   assign mr   = {{(36 - RW){1'b0}}, r_ff};
   assign mtca = mag36(tca_ff);
   assign mdx  = mag36(36'(dx_ff));
   assign mdy  = mag36(36'(dy_ff));
   assign mdz  = mag36(36'(dz_ff));

   // Operand schedule of the shared multiplier; squares take a low and a high half.
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      op_neg   = 1'b0;
      op_shift = 1'b0;
      op_first = 1'b0;
      op_last  = 1'b0;
      case (step_ff)
         STEP_LX_LO:  begin op_a = mlx; op_b = mlx[17:0]; op_first = 1'b1; end
         STEP_LX_HI:  begin op_a = mlx; op_b = mlx[35:18]; op_shift = 1'b1; end
         STEP_LY_LO:  begin op_a = mly; op_b = mly[17:0]; end
         STEP_LY_HI:  begin op_a = mly; op_b = mly[35:18]; op_shift = 1'b1; end
         STEP_LZ_LO:  begin op_a = mlz; op_b = mlz[17:0]; end
         STEP_LZ_HI:  begin
            op_a = mlz; op_b = mlz[35:18]; op_shift = 1'b1; op_last = 1'b1;
         end
         STEP_R_LO:   begin op_a = mr; op_b = mr[17:0]; op_first = 1'b1; end
         STEP_R_HI:   begin
            op_a = mr; op_b = mr[35:18]; op_shift = 1'b1; op_last = 1'b1;
         end
         STEP_DOT_X:  begin
            op_a = mlx; op_b = mdx[17:0]; op_neg = lx_ff[LW-1] ^ dx_ff[15];
            op_first = 1'b1;
         end
         STEP_DOT_Y:  begin
            op_a = mly; op_b = mdy[17:0]; op_neg = ly_ff[LW-1] ^ dy_ff[15];
         end
         STEP_DOT_Z:  begin
            op_a = mlz; op_b = mdz[17:0]; op_neg = lz_ff[LW-1] ^ dz_ff[15];
            op_last = 1'b1;
         end
         STEP_TCA_LO: begin op_a = mtca; op_b = mtca[17:0]; op_first = 1'b1; end
         STEP_TCA_HI: begin
            op_a = mtca; op_b = mtca[35:18]; op_shift = 1'b1; op_last = 1'b1;
         end
         default:     begin op_a = '0; end
      endcase
   end

   assign term  = op_shift ? {prod_ff, 18'b0} : {18'b0, prod_ff};
   assign sterm = op_neg ? (~term + 72'd1) : term;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      lx_in = lx_ff; ly_in = ly_ff; lz_in = lz_ff;
      r_in         = r_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      l2_in        = l2_ff;
      r2_in        = r2_ff;
      tca_in       = tca_ff;
      d2_in        = d2_ff;
      sq_start_in  = 1'b0;
      sq_rad_in    = sq_rad_ff;
      t_in         = t_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      ram_we       = 1'b0;

      if (csr_ch.valid) begin
         active_in = csr_ch.active_spheres;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == nrsh_pkg::KIND_LOAD) begin
                  ram_we = slot_ok;
               end else begin
                  ox_in = req_ch.pos_x; oy_in = req_ch.pos_y; oz_in = req_ch.pos_z;
                  dx_in = req_ch.dir_x; dy_in = req_ch.dir_y; dz_in = req_ch.dir_z;
                  n_in     = n_sel;
                  i_in     = '0;
                  found_in = 1'b0;
                  best_in  = '0;
                  idx_in   = '0;
                  state_in = (n_sel == '0) ? ST_DONE : ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            lx_in = LW'(signed'(ram_rdata[3*PW+RW-1 -: PW])) - LW'(ox_ff);
            ly_in = LW'(signed'(ram_rdata[2*PW+RW-1 -: PW])) - LW'(oy_ff);
            lz_in = LW'(signed'(ram_rdata[PW+RW-1 -: PW])) - LW'(oz_ff);
            r_in     = ram_rdata[RW-1:0];
            step_in  = STEP_LX_LO;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = 54'(op_a) * 54'(op_b);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = op_first ? sterm : acc_ff + sterm;
            if (op_last) begin
               state_in = ST_CHECK;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            step_in  = step_ff + 4'd1;
            state_in = ST_MUL;
            case (step_ff)
               STEP_LZ_HI: l2_in = acc_ff[65:0];
               STEP_R_HI: begin
                  r2_in = acc_ff[61:0];
                  // Origin strictly inside the sphere.
                  if (l2_ff < {4'b0, acc_ff[61:0]}) begin
                     state_in = ST_NEXT;
                  end
               end
               STEP_DOT_Z: begin
                  // Floor of the Q.31 dot product to Q20.16.
                  tca_in = acc_ff[50:15];
                  if (acc_ff[50] && ({4'b0, r2_ff} < l2_ff)) begin
                     state_in = ST_NEXT;
                  end
               end
               STEP_TCA_HI: begin
                  if ({6'b0, l2_ff} < acc_ff) begin
                     d2_in = '0;
                  end else begin
                     d2_in = l2_ff - acc_ff[65:0];
                  end
                  state_in = ST_DIFF;
               end
               default: state_in = ST_NEXT;
            endcase
         end
         ST_DIFF: begin
            if (d2_ff > {4'b0, r2_ff}) begin
               state_in = ST_NEXT;
            end else begin
               sq_rad_in   = r2_ff - d2_ff[61:0];
               sq_start_in = 1'b1;
               state_in    = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               t_in     = 37'(tca_ff) - 37'(sq_root);
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!found_ff || (t_ff < best_ff)) begin
               found_in = 1'b1;
               best_in  = t_ff;
               idx_in   = i_ext[nrsh_pkg::SLOT_W-1:0];
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            i_in     = i_ff + CW'(1);
            state_in = ((i_ff + CW'(1)) == n_ff) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_index_in = found_ff ? idx_ff : '0;
               if (!found_ff) begin
                  rsp_dist_in = '0;
               end else if (!best_ff[36] && (best_ff[35:31] != 5'b00000)) begin
                  rsp_dist_in = 32'h7FFF_FFFF;
               end else if (best_ff[36] && (best_ff[35:31] != 5'b11111)) begin
                  rsp_dist_in = 32'h8000_0000;
               end else begin
                  rsp_dist_in = best_ff[31:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         sq_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         sq_start_ff  <= sq_start_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      lx_ff <= lx_in; ly_ff <= ly_in; lz_ff <= lz_in;
      r_ff         <= r_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      l2_ff        <= l2_in;
      r2_ff        <= r2_in;
      tca_ff       <= tca_in;
      d2_ff        <= d2_in;
      sq_rad_ff    <= sq_rad_in;
      t_ff         <= t_in;
      best_ff      <= best_in;
      idx_ff       <= idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.hit_index    = rsp_index_ff;
   assign rsp_ch.hit_distance = rsp_dist_ff;

   a_resp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (i_ff < n_ff))
      else $error("table read beyond the searched count");

   a_sqrt_done_owned: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SQRT))
      else $error("square root finished while not awaited");

   a_no_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.hit) |-> (rsp_ch.hit_index == '0 && rsp_ch.hit_distance == '0))
      else $error("miss response carries a nonzero index or distance");

endmodule

// ----- test/testbench.sv -----
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE   = 64;
   localparam int IDLE_LIMIT   = 40000;
   localparam int SETTLE_WAIT  = 40;
   localparam int RANDOM_ITEMS = 650;

   typedef struct packed {
      logic                               hit;
      logic [nrsh_pkg::SLOT_W-1:0]        hit_index;
      logic signed [nrsh_pkg::DIST_W-1:0] hit_distance;
   } hit_result_type;

   logic clock;
   logic reset;

   nrsh_req_if req_bus ();
   nrsh_rsp_if rsp_bus ();
   nrsh_csr_if csr_bus ();

   nearest_ray_sphere_hit_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Shadow copy of the sphere table and the search count.
   logic signed [nrsh_pkg::POS_W-1:0] center_x [TABLE_SIZE];
   logic signed [nrsh_pkg::POS_W-1:0] center_y [TABLE_SIZE];
   logic signed [nrsh_pkg::POS_W-1:0] center_z [TABLE_SIZE];
   logic [nrsh_pkg::RAD_W-1:0]        sphere_radius [TABLE_SIZE];
   logic [nrsh_pkg::CNT_W-1:0]        search_count;

   hit_result_type pending_hits[$];
   int  fail_count;
   int  idle_cycles;
   int  items_sent;
   int  burst_left;
   bit  req_up;
   int  stall_cycle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x)
         b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic hit_result_type nearest_hit(logic signed [nrsh_pkg::POS_W-1:0] ox,
                                                  logic signed [nrsh_pkg::POS_W-1:0] oy,
                                                  logic signed [nrsh_pkg::POS_W-1:0] oz,
                                                  logic signed [nrsh_pkg::DIR_W-1:0] dx,
                                                  logic signed [nrsh_pkg::DIR_W-1:0] dy,
                                                  logic signed [nrsh_pkg::DIR_W-1:0] dz);
      hit_result_type res;
      logic signed [79:0] lx, ly, lz, l2, r2, t2, d2, tw;
      longint dot, tca, thc, span, best;
      bit found;
      int idx, n;
      found = 0;
      best = 0;
      idx = 0;
      n = (search_count > TABLE_SIZE) ? TABLE_SIZE : search_count;
      for (int i = 0; i < n; i++) begin
         lx = 80'(longint'(center_x[i]) - longint'(ox));
         ly = 80'(longint'(center_y[i]) - longint'(oy));
         lz = 80'(longint'(center_z[i]) - longint'(oz));
         l2 = lx * lx + ly * ly + lz * lz;
         tw = {49'd0, sphere_radius[i]};
         r2 = tw * tw;
         if (l2 < r2)
            continue;
         dot = longint'(lx) * longint'(dx) + longint'(ly) * longint'(dy)
               + longint'(lz) * longint'(dz);
         tca = dot >>> 15;
         if (tca < 0 && r2 < l2)
            continue;
         tw = 80'(tca);
         t2 = tw * tw;
         d2 = (l2 < t2) ? 80'sd0 : l2 - t2;
         if (d2 > r2)
            continue;
         thc = longint'(root_floor(64'(r2 - d2)));
         span = tca - thc;
         if (found && span >= best)
            continue;
         found = 1;
         best = span;
         idx = i;
      end
      res = '0;
      if (found) begin
         res.hit = 1'b1;
         res.hit_index = idx[nrsh_pkg::SLOT_W-1:0];
         if (best > 64'sd2147483647)
            res.hit_distance = 32'h7FFF_FFFF;
         else if (best < -64'sd2147483648)
            res.hit_distance = 32'h8000_0000;
         else
            res.hit_distance = best[31:0];
      end
      return res;
   endfunction

   // Sends one request, updates the shadow state on acceptance, then maybe
   // ends the burst with a random gap.
   task automatic send_request(logic k, logic [nrsh_pkg::SLOT_W-1:0] s,
                               logic signed [nrsh_pkg::POS_W-1:0] px,
                               logic signed [nrsh_pkg::POS_W-1:0] py,
                               logic signed [nrsh_pkg::POS_W-1:0] pz,
                               logic [nrsh_pkg::RAD_W-1:0] r,
                               logic signed [nrsh_pkg::DIR_W-1:0] dx,
                               logic signed [nrsh_pkg::DIR_W-1:0] dy,
                               logic signed [nrsh_pkg::DIR_W-1:0] dz);
      req_bus.valid  <= 1'b1;
      req_up = 1;
      req_bus.kind   <= k;
      req_bus.slot   <= s;
      req_bus.pos_x  <= px;
      req_bus.pos_y  <= py;
      req_bus.pos_z  <= pz;
      req_bus.radius <= r;
      req_bus.dir_x  <= dx;
      req_bus.dir_y  <= dy;
      req_bus.dir_z  <= dz;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
      if (k == nrsh_pkg::KIND_LOAD) begin
         center_x[s] = px;
         center_y[s] = py;
         center_z[s] = pz;
         sphere_radius[s] = r;
      end else begin
         pending_hits.push_back(nearest_hit(px, py, pz, dx, dy, dz));
      end
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         req_up = 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 0;
      end
      while (pending_hits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_search_count(logic [nrsh_pkg::CNT_W-1:0] value);
      drain_results();
      csr_bus.valid          <= 1'b1;
      csr_bus.active_spheres <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      search_count = value;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [nrsh_pkg::POS_W-1:0] near_coord();
      return ($signed($urandom_range(0, 200)) - 100) * 65536
             + $signed($urandom_range(0, 65535));
   endfunction

   task automatic load_sphere(int s, int ux, int uy, int uz, int ur);
      send_request(nrsh_pkg::KIND_LOAD, nrsh_pkg::SLOT_W'(s), ux * 65536, uy * 65536,
                   uz * 65536, nrsh_pkg::RAD_W'(ur * 65536), '0, '0, '0);
   endtask

   task automatic load_random_sphere(int s);
      send_request(nrsh_pkg::KIND_LOAD, nrsh_pkg::SLOT_W'(s), near_coord(), near_coord(),
                   near_coord(), nrsh_pkg::RAD_W'($urandom_range(65536, 20 * 65536)),
                   nrsh_pkg::DIR_W'($urandom), nrsh_pkg::DIR_W'($urandom),
                   nrsh_pkg::DIR_W'($urandom));
   endtask

   task automatic load_noise();
      send_request(nrsh_pkg::KIND_LOAD, nrsh_pkg::SLOT_W'($urandom), $urandom, $urandom,
                   $urandom, nrsh_pkg::RAD_W'($urandom), nrsh_pkg::DIR_W'($urandom),
                   nrsh_pkg::DIR_W'($urandom), nrsh_pkg::DIR_W'($urandom));
   endtask

   // Aims a ray from a random origin at the chosen slot, with some jitter.
   task automatic send_aimed_query(int target);
      logic signed [nrsh_pkg::POS_W-1:0] ox, oy, oz;
      real vx, vy, vz, len;
      ox = near_coord();
      oy = near_coord();
      oz = near_coord();
      vx = $itor(center_x[target] - ox) + $itor($signed($urandom_range(0, 400000)) - 200000);
      vy = $itor(center_y[target] - oy) + $itor($signed($urandom_range(0, 400000)) - 200000);
      vz = $itor(center_z[target] - oz) + $itor($signed($urandom_range(0, 400000)) - 200000);
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      if (len < 1.0) begin
         vx = 1.0;
         len = 1.0;
      end
      send_request(nrsh_pkg::KIND_QUERY, nrsh_pkg::SLOT_W'($urandom), ox, oy, oz,
                   nrsh_pkg::RAD_W'($urandom),
                   nrsh_pkg::DIR_W'(int'(vx / len * 32767.0)),
                   nrsh_pkg::DIR_W'(int'(vy / len * 32767.0)),
                   nrsh_pkg::DIR_W'(int'(vz / len * 32767.0)));
   endtask

   task automatic send_noise_query();
      send_request(nrsh_pkg::KIND_QUERY, nrsh_pkg::SLOT_W'($urandom), $urandom, $urandom,
                   $urandom, nrsh_pkg::RAD_W'($urandom), nrsh_pkg::DIR_W'($urandom),
                   nrsh_pkg::DIR_W'($urandom), nrsh_pkg::DIR_W'($urandom));
   endtask

   task automatic test_table_fill();
      // Hand-placed spheres for the corner cases, the rest random.
      load_sphere(0, 10, 0, 0, 2);
      load_sphere(1, 10, 0, 0, 2);
      load_sphere(2, 0, 0, 0, 5);
      load_sphere(3, -10, 0, 0, 1);
      send_request(nrsh_pkg::KIND_LOAD, 6'd4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(nrsh_pkg::KIND_LOAD, 6'd5, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, 31'd0, 16'sh8000, 16'sh8000, 16'sh8000);
      load_sphere(6, 3, 0, 0, 3);
      for (int s = 7; s < TABLE_SIZE; s++)
         load_random_sphere(s);
   endtask

   task automatic test_search_count();
      write_search_count(7'd0);
      send_request(nrsh_pkg::KIND_QUERY, '0, '0, '0, '0, '0, 16'sd32767, '0, '0);
      write_search_count(7'd127);
      send_request(nrsh_pkg::KIND_QUERY, '0, '0, '0, '0, '0, 16'sd32767, '0, '0);
      write_search_count(7'd64);
      send_aimed_query(40);
   endtask

   task automatic test_special_rays();
      write_search_count(7'd7);
      // Along +x from the center of slot 2: inside slot 2, tie on 0 and 1,
      // origin exactly on the surface of slot 6.
      send_request(nrsh_pkg::KIND_QUERY, '0, '0, '0, '0, '0, 16'sd32767, '0, '0);
      // Along -x: slot 3 ahead, slot 6 touched from its surface going away.
      send_request(nrsh_pkg::KIND_QUERY, '0, '0, '0, '0, '0, 16'sh8000, '0, '0);
      // From far along +x looking back: spheres behind and in front.
      send_request(nrsh_pkg::KIND_QUERY, '0, 32'sd20 * 65536, 32'sd1 * 65536, '0, '0,
                   16'sh8000, '0, '0);
      // Clean miss along +y from off axis.
      send_request(nrsh_pkg::KIND_QUERY, '0, 32'sd50 * 65536, '0, '0, '0, '0,
                   16'sd32767, '0);
      // Extreme origins and a far-from-unit direction.
      send_request(nrsh_pkg::KIND_QUERY, '0, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(nrsh_pkg::KIND_QUERY, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, '0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_request(nrsh_pkg::KIND_QUERY, '0, '0, '0, '0, '0, '0, '0, '0);
   endtask

   task automatic test_random_traffic();
      int count, queries, pick, limit;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            count = 0;
         else if (pick == 1)
            count = 64;
         else if (pick == 2)
            count = $urandom_range(65, 127);
         else
            count = $urandom_range(1, 12);
         write_search_count(nrsh_pkg::CNT_W'(count));
         limit = (count > TABLE_SIZE) ? TABLE_SIZE : count;
         queries = (count > 16) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         for (int q = 0; q < queries; q++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               load_noise();
            end else if (pick < 3) begin
               load_random_sphere($urandom_range(0, TABLE_SIZE - 1));
            end else if (pick == 3) begin
               send_noise_query();
            end else begin
               send_aimed_query((limit == 0) ? 0 : $urandom_range(0, limit - 1));
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = nrsh_pkg::KIND_LOAD;
      req_bus.slot = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.radius = '0;
      req_bus.dir_x = '0;
      req_bus.dir_y = '0;
      req_bus.dir_z = '0;
      csr_bus.valid = 1'b0;
      csr_bus.active_spheres = '0;
      search_count = '0;
      fail_count = 0;
      items_sent = 0;
      burst_left = 0;
      req_up = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_search_count();
      test_special_rays();
      test_random_traffic();
      drain_results();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Response side: checks each accepted result and stalls on a rotating
   // pattern, including long stretches with no stall at all.
   always @(posedge clock) begin
      hit_result_type want;
      stall_cycle <= stall_cycle + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_hits.size() == 0) begin
            $error("unexpected result: hit %0d index %0d distance %0d",
                   rsp_bus.hit, rsp_bus.hit_index, rsp_bus.hit_distance);
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
               fail_count++;
            end
            if (rsp_bus.hit_index !== want.hit_index) begin
               $error("hit_index: expected %0d, got %0d", want.hit_index, rsp_bus.hit_index);
               fail_count++;
            end
            if (rsp_bus.hit_distance !== want.hit_distance) begin
               $error("hit_distance: expected %0d, got %0d",
                      want.hit_distance, rsp_bus.hit_distance);
               fail_count++;
            end
         end
      end
      case (stall_cycle[10:9])
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= (stall_cycle[2:0] != 3'd0);
         2'd2: rsp_bus.ready <= stall_cycle[4];
         default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial stall_cycle = 0;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial idle_cycles = 0;

endmodule
